>>> rtl/core/svm_pkg.sv
// Shared definitions for the saturating voice mixer.
// Command codes, field widths and the address wrap unit status.
// No dependencies.
package svm_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IN_ADDR_W  = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUEUE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wrap_stat_t;

endpackage

>>> rtl/core/svm_ram.sv
// Single-port synchronous RAM with registered read data.
// Used for the sample store and the voice table; no dependencies.
module svm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/svm_addr_wrap.sv
// Address reduction modulo DEPTH in three registered steps: reciprocal multiply
// for a quotient estimate, multiply-subtract for the remainder, one correction.
// Depends on svm_pkg for widths and the status struct.
module svm_addr_wrap #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [svm_pkg::IN_ADDR_W-1:0]    addr_in,
  output logic [svm_pkg::IN_ADDR_W-1:0]    wrap_addr,
  output svm_pkg::wrap_stat_t              stat
);

  localparam int unsigned    SHIFT = 32;
  localparam int unsigned    PW    = 48;
  localparam logic [PW-1:0]  RECIP = PW'((64'd1 << SHIFT) / 64'(DEPTH));

  typedef enum logic [1:0] {
    P_QUOT, P_REM, P_FIX
  } phase_t;

  logic                            busy_r;
  logic                            done_r;
  phase_t                          phase_r;
  logic [svm_pkg::IN_ADDR_W-1:0]   val_r;
  logic [svm_pkg::IN_ADDR_W-1:0]   quot_r;
  logic [PW-1:0]                   prod;
  logic [PW-1:0]                   part;
  logic [PW-1:0]                   rest;
  logic [PW-1:0]                   fold;
  logic [svm_pkg::IN_ADDR_W-1:0]   val_fix;

  always_comb begin
    prod    = PW'(val_r) * RECIP;
    part    = PW'(quot_r) * PW'(DEPTH);
    rest    = PW'(val_r) - part;
    fold    = PW'(val_r) - PW'(DEPTH);
    val_fix = (PW'(val_r) >= PW'(DEPTH)) ? fold[svm_pkg::IN_ADDR_W-1:0] : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= P_QUOT;
        val_r   <= addr_in;
      end else if (busy_r) begin
        unique case (phase_r)
          P_QUOT: begin
            quot_r  <= prod[SHIFT+svm_pkg::IN_ADDR_W-1:SHIFT];
            phase_r <= P_REM;
          end
          P_REM: begin
            val_r   <= rest[svm_pkg::IN_ADDR_W-1:0];
            phase_r <= P_FIX;
          end
          P_FIX: begin
            val_r  <= val_fix;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          default: begin
            busy_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign wrap_addr = val_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/core/saturating_voice_mixer_top.sv
// Top level of the saturating voice mixer: command sequencer, voice busy flags,
// sample RAM, voice table RAM and address wrap unit. Depends on svm_pkg,
// svm_ram and svm_addr_wrap.
//
// channel | dir | handshake            | contents
// in      | in  | in_tvalid/in_tready  | tuser command, tdata address/sample/length
// out     | out | out_tvalid/out_tready| tdata mixed sample/accepted/voice count
//
// Steps from accept to result: write: wrap start, 3-step address wrap, RAM write,
// output; queue: slot scan, then as a write, or rejected when no slot is free. Tick:
// an idle slot is skipped, a freed slot is released, a playing slot gets voice table
// read, sample read, saturating add; then output. No clearing pass after reset.
// A new item is taken in the cycle after the result is loaded, while it waits at the
// output register; a stalled output holds the sequencer with the next result.
module saturating_voice_mixer_top #(
  parameter int unsigned VOICES       = 16,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [55:0]: address[15:0], sample_word[31:16], clip_length[48:32], zero pad
  input  logic [svm_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0]: command
  input  logic [svm_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [23:0]: mixed_sample[15:0], accepted[16], active_voices[21:17], zero pad
  output logic [svm_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned SW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned VW   = AW + svm_pkg::LEN_W;
  localparam int unsigned CNTW = $clog2(VOICES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRAP, S_VRD, S_VCHK, S_ACC, S_DONE
  } state_t;

  state_t                              state_r;
  svm_pkg::cmd_t                       cmd_r;
  logic [svm_pkg::IN_ADDR_W-1:0]       addr_in_r;
  logic [svm_pkg::SAMPLE_W-1:0]        sample_r;
  logic [svm_pkg::LEN_W-1:0]           len_r;
  logic [SW-1:0]                       slot_r;
  logic [VOICES-1:0]                   busy_r;
  logic signed [svm_pkg::SAMPLE_W-1:0] acc_r;
  logic [CNTW-1:0]                     cnt_r;
  logic                                ok_r;
  logic                                wrap_start_r;
  logic                                out_valid_r;
  logic [svm_pkg::OUT_DATA_W-1:0]      out_tdata_r;

  logic [svm_pkg::IN_ADDR_W-1:0]       wrap_addr;
  svm_pkg::wrap_stat_t                 wrap_stat;

  logic                                smp_we;
  logic                                smp_re;
  logic [AW-1:0]                       smp_addr;
  logic [svm_pkg::SAMPLE_W-1:0]        smp_rdata;
  logic                                voice_we;
  logic                                voice_re;
  logic [VW-1:0]                       voice_wdata;
  logic [VW-1:0]                       voice_rdata;

  logic [AW-1:0]                       v_addr;
  logic [svm_pkg::LEN_W-1:0]           v_rem;
  logic [AW-1:0]                       v_addr_inc;
  logic                                v_live;
  logic                                slot_last;
  logic                                slot_busy;
  logic signed [svm_pkg::SAMPLE_W:0]   sum;
  logic signed [svm_pkg::SAMPLE_W-1:0] sum_sat;
  logic [CNTW+svm_pkg::COUNT_W-1:0]    cnt_ext;
  logic                                out_free;
  logic                                wrap_commit;

  always_comb begin
    v_addr     = voice_rdata[AW-1:0];
    v_rem      = voice_rdata[VW-1:AW];
    v_addr_inc = (v_addr == AW'(SAMPLE_DEPTH - 1)) ? '0 : v_addr + 1'b1;
    v_live     = (v_rem != '0);
    slot_last  = (slot_r == SW'(VOICES - 1));
    slot_busy  = busy_r[slot_r];
    sum        = {acc_r[svm_pkg::SAMPLE_W-1], acc_r} +
                 {smp_rdata[svm_pkg::SAMPLE_W-1], smp_rdata};
    if (sum[svm_pkg::SAMPLE_W] == sum[svm_pkg::SAMPLE_W-1]) begin
      sum_sat = sum[svm_pkg::SAMPLE_W-1:0];
    end else if (sum[svm_pkg::SAMPLE_W]) begin
      sum_sat = {1'b1, {(svm_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(svm_pkg::SAMPLE_W-1){1'b1}}};
    end
    cnt_ext     = {{svm_pkg::COUNT_W{1'b0}}, cnt_r};
    out_free    = !out_valid_r || out_tready;
    wrap_commit = (state_r == S_WRAP) && wrap_stat.done;

    smp_we   = wrap_commit && (cmd_r == svm_pkg::CMD_WRITE);
    smp_re   = (state_r == S_VCHK) && v_live;
    smp_addr = smp_we ? AW'(wrap_addr) : v_addr;

    voice_re = (state_r == S_VRD) && slot_busy;
    voice_we = (wrap_commit && (cmd_r == svm_pkg::CMD_QUEUE)) || smp_re;
    if (state_r == S_VCHK) begin
      voice_wdata = {v_rem - 1'b1, v_addr_inc};
    end else begin
      voice_wdata = {len_r, AW'(wrap_addr)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      busy_r       <= '0;
      cnt_r        <= '0;
      wrap_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wrap_start_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= svm_pkg::cmd_t'(in_tuser);
            addr_in_r <= in_tdata[15:0];
            sample_r  <= in_tdata[31:16];
            len_r     <= in_tdata[48:32];
            slot_r    <= '0;
            acc_r     <= '0;
            cnt_r     <= '0;
            ok_r      <= 1'b0;
            case (svm_pkg::cmd_t'(in_tuser))
              svm_pkg::CMD_WRITE: begin
                wrap_start_r <= 1'b1;
                state_r      <= S_WRAP;
              end
              svm_pkg::CMD_QUEUE: begin
                state_r <= (in_tdata[48:32] == '0) ? S_DONE : S_SCAN;
              end
              svm_pkg::CMD_TICK: begin
                ok_r    <= 1'b1;
                state_r <= S_VRD;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!slot_busy) begin
            wrap_start_r <= 1'b1;
            state_r      <= S_WRAP;
          end else if (slot_last) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_WRAP: begin
          if (wrap_stat.done) begin
            ok_r <= 1'b1;
            if (cmd_r == svm_pkg::CMD_QUEUE) begin
              busy_r[slot_r] <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_VRD: begin
          if (slot_busy) begin
            state_r <= S_VCHK;
          end else if (slot_last) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_VCHK: begin
          if (v_live) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_ACC;
          end else begin
            busy_r[slot_r] <= 1'b0;
            if (slot_last) begin
              state_r <= S_DONE;
            end else begin
              slot_r  <= slot_r + 1'b1;
              state_r <= S_VRD;
            end
          end
        end
        S_ACC: begin
          acc_r <= sum_sat;
          if (slot_last) begin
            state_r <= S_DONE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_VRD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_tdata_r <= {2'b00, cnt_ext[svm_pkg::COUNT_W-1:0], ok_r, acc_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  svm_ram #(
    .WIDTH (svm_pkg::SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW)
  ) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .re    (smp_re),
    .addr  (smp_addr),
    .wdata (sample_r),
    .rdata (smp_rdata)
  );

  svm_ram #(
    .WIDTH (VW),
    .DEPTH (VOICES),
    .AW    (SW)
  ) u_voice_ram (
    .clk   (clk),
    .we    (voice_we),
    .re    (voice_re),
    .addr  (slot_r),
    .wdata (voice_wdata),
    .rdata (voice_rdata)
  );

  svm_addr_wrap #(
    .DEPTH (SAMPLE_DEPTH)
  ) u_addr_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (wrap_start_r),
    .addr_in   (addr_in_r),
    .wrap_addr (wrap_addr),
    .stat      (wrap_stat)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_check_slot_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VCHK) |-> busy_r[slot_r])
    else $error("voice table read for a free slot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(VOICES))
    else $error("voice count above slot count");

  a_queue_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (wrap_commit && (cmd_r == svm_pkg::CMD_QUEUE)) |=> busy_r[$past(slot_r)])
    else $error("queued clip did not claim its slot");

  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_stat.done |-> (32'(wrap_addr) < SAMPLE_DEPTH))
    else $error("wrapped address out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result overwrote a pending item");
`endif

endmodule

>>> dv/svm_mix_checker.sv
`timescale 1ns / 100ps
// Result checker for the saturating voice mixer: keeps its own sample memory and
// voice table, predicts each result as commands are taken, and compares results
// on the output stream. Depends on svm_pkg.
module svm_mix_checker #(
  parameter int unsigned VOICES       = 16,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [svm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [svm_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [svm_pkg::OUT_DATA_W-1:0] out_tdata,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_due
);

  localparam int          AW_IN      = svm_pkg::IN_ADDR_W;
  localparam int          SW_IN      = svm_pkg::SAMPLE_W;
  localparam int          LW_IN      = svm_pkg::LEN_W;
  localparam int          WORD_LO    = AW_IN;
  localparam int          LEN_LO     = AW_IN + SW_IN;
  localparam int          MIX_MAX    = 32767;
  localparam int          MIX_MIN    = -32768;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [svm_pkg::COUNT_W-1:0] voices;
    logic                        accepted;
    logic signed [SW_IN-1:0]     mixed;
  } mix_result_t;

  logic [SW_IN-1:0] sample_mem [SAMPLE_DEPTH];
  logic             voice_on   [VOICES];
  int unsigned      voice_ptr  [VOICES];
  logic [LW_IN-1:0] voice_left [VOICES];
  mix_result_t      mixes_due  [$];
  int unsigned      fails = 0;

  function automatic mix_result_t mix_command(input logic [svm_pkg::CMD_W-1:0] cmd,
                                              input logic [svm_pkg::IN_DATA_W-1:0] data);
    mix_result_t      res;
    logic [AW_IN-1:0] addr;
    logic [LW_IN-1:0] len;
    int               acc;
    bit               placed;
    res    = '0;
    acc    = 0;
    placed = 1'b0;
    addr   = data[AW_IN-1:0];
    len    = data[LEN_LO+LW_IN-1:LEN_LO];
    case (cmd)
      svm_pkg::CMD_WRITE: begin
        sample_mem[addr % SAMPLE_DEPTH] = data[WORD_LO+SW_IN-1:WORD_LO];
        res.accepted = 1'b1;
      end
      svm_pkg::CMD_QUEUE: begin
        if (len != 0) begin
          for (int v = 0; v < VOICES; v++) begin
            if (!placed && !voice_on[v]) begin
              voice_on[v]   = 1'b1;
              voice_ptr[v]  = addr % SAMPLE_DEPTH;
              voice_left[v] = len;
              placed        = 1'b1;
            end
          end
        end
        res.accepted = placed;
      end
      svm_pkg::CMD_TICK: begin
        res.accepted = 1'b1;
        for (int v = 0; v < VOICES; v++) begin
          if (voice_on[v]) begin
            if (voice_left[v] == 0) begin
              voice_on[v] = 1'b0;
            end else begin
              acc += $signed(sample_mem[voice_ptr[v]]);
              if (acc > MIX_MAX) begin
                acc = MIX_MAX;
              end else if (acc < MIX_MIN) begin
                acc = MIX_MIN;
              end
              voice_ptr[v]  = (voice_ptr[v] + 1) % SAMPLE_DEPTH;
              voice_left[v] = voice_left[v] - 1'b1;
              res.voices    = res.voices + 1'b1;
            end
          end
        end
        res.mixed = acc[SW_IN-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    mix_result_t got;
    mix_result_t want;
    if (!rst_n) begin
      for (int v = 0; v < VOICES; v++) begin
        voice_on[v]   = 1'b0;
        voice_ptr[v]  = 0;
        voice_left[v] = '0;
      end
      mixes_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        mixes_due.push_back(mix_command(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = mix_result_t'(out_tdata[$bits(mix_result_t)-1:0]);
        if (mixes_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) begin
            $display("%0t: unexpected result: sample %0d accepted %0b voices %0d",
                     $realtime, got.mixed, got.accepted, got.voices);
          end
        end else begin
          want = mixes_due.pop_front();
          if (got.mixed !== want.mixed || got.accepted !== want.accepted ||
              got.voices !== want.voices) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("%0t: mismatch: want %0d/%0b/%0d got %0d/%0b/%0d",
                       $realtime, want.mixed, want.accepted, want.voices,
                       got.mixed, got.accepted, got.voices);
            end
          end
        end
      end
    end
    mismatch_count <= fails;
    results_due    <= mixes_due.size();
  end

endmodule

>>> dv/saturating_voice_mixer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the saturating voice mixer: clock, reset, write/queue/tick
// and unused-command stimulus with random idling on both streams, and the verdict.
// Depends on svm_pkg, saturating_voice_mixer_top and svm_mix_checker.
module saturating_voice_mixer_top_tb;

  localparam int unsigned      VOICES       = 16;
  localparam int unsigned      SAMPLE_DEPTH = 65536;
  localparam int unsigned      ITEM_TARGET  = 800;
  localparam int unsigned      CALM_FIRST   = 300;
  localparam int unsigned      CALM_LAST    = 420;
  localparam int unsigned      AW_IN        = svm_pkg::IN_ADDR_W;
  localparam int unsigned      SW_IN        = svm_pkg::SAMPLE_W;
  localparam int unsigned      LW_IN        = svm_pkg::LEN_W;
  localparam logic [svm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [LW_IN-1:0] LEN_MAX      = 17'h1FFFF;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [svm_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic [svm_pkg::CMD_W-1:0]      in_tuser  = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [svm_pkg::OUT_DATA_W-1:0] out_tdata;
  int unsigned                    mismatch_count;
  int unsigned                    results_due;

  bit          calm = 1'b0;
  int unsigned items_sent = 0;
  bit          addr_written [SAMPLE_DEPTH];
  bit          slot_busy    [VOICES];
  int unsigned slot_ptr     [VOICES];
  int unsigned slot_left    [VOICES];

  always #4 clk = ~clk;

  saturating_voice_mixer_top #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  svm_mix_checker #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) mix_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always @(posedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(0, 99) >= 33);
  end

  function automatic logic [AW_IN-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return AW_IN'($urandom);
      1:       return 16'hFFF8 + AW_IN'($urandom_range(0, 15));
      default: return AW_IN'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [SW_IN-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return '1;
      default: return SW_IN'($urandom);
    endcase
  endfunction

  function automatic logic [LW_IN-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      return '0;
    end else if (r < 8) begin
      case ($urandom_range(0, 2))
        0:       return LEN_MAX;
        1:       return 17'h10000;
        default: return LW_IN'($urandom);
      endcase
    end
    return LW_IN'($urandom_range(1, 12));
  endfunction

  task automatic send_item(input logic [svm_pkg::CMD_W-1:0] cmd,
                           input logic [AW_IN-1:0]          addr,
                           input logic [SW_IN-1:0]          word,
                           input logic [LW_IN-1:0]          len);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= svm_pkg::IN_DATA_W'({len, word, addr});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic do_write(input logic [AW_IN-1:0] addr, input logic [SW_IN-1:0] word);
    send_item(svm_pkg::CMD_WRITE, addr, word, LW_IN'($urandom));
    addr_written[addr] = 1'b1;
  endtask

  task automatic do_queue(input logic [AW_IN-1:0] addr, input logic [LW_IN-1:0] len);
    bit placed;
    placed = 1'b0;
    send_item(svm_pkg::CMD_QUEUE, addr, SW_IN'($urandom), len);
    if (len != 0) begin
      for (int v = 0; v < VOICES; v++) begin
        if (!placed && !slot_busy[v]) begin
          slot_busy[v] = 1'b1;
          slot_ptr[v]  = addr % SAMPLE_DEPTH;
          slot_left[v] = 32'(len);
          placed       = 1'b1;
        end
      end
    end
  endtask

  // fill any sample a playing voice is about to read, so no unwritten word is mixed
  task automatic do_tick();
    for (int v = 0; v < VOICES; v++) begin
      if (slot_busy[v] && slot_left[v] != 0 && !addr_written[slot_ptr[v]]) begin
        do_write(AW_IN'(slot_ptr[v]), pick_sample());
      end
    end
    send_item(svm_pkg::CMD_TICK, AW_IN'($urandom), SW_IN'($urandom), LW_IN'($urandom));
    for (int v = 0; v < VOICES; v++) begin
      if (slot_busy[v]) begin
        if (slot_left[v] == 0) begin
          slot_busy[v] = 1'b0;
        end else begin
          slot_ptr[v]  = (slot_ptr[v] + 1) % SAMPLE_DEPTH;
          slot_left[v] = slot_left[v] - 1;
        end
      end
    end
  endtask

  initial begin
    int unsigned pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    do_write(16'h0000, 16'h7FFF);
    do_write(16'hFFFF, 16'h8000);
    do_write(16'h0001, 16'hFFFF);
    send_item(CMD_UNUSED, '1, '1, '1);
    do_queue(16'hFFFF, '0);
    do_tick();
    // drive the sum to both rails, then fill every slot and overflow
    do_queue(16'hFFFF, 17'd3);
    repeat (7) do_queue(16'hFFFF, 17'd1);
    repeat (8) do_queue(16'h0000, 17'd1);
    do_queue(16'hFFFF, LEN_MAX);
    repeat (2) do_tick();
    do_queue(16'h8000, LEN_MAX);
    do_queue(16'h7FFF, 17'h10000);
    repeat (2) do_tick();

    while (items_sent < ITEM_TARGET) begin
      calm <= items_sent >= CALM_FIRST && items_sent < CALM_LAST;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        repeat (VOICES) do_queue(pick_addr(), LW_IN'($urandom_range(1, 12)));
      end else if (pick < 33) begin
        do_write(pick_addr(), pick_sample());
      end else if (pick < 55) begin
        do_queue(pick_addr(), pick_len());
      end else if (pick < 95) begin
        do_tick();
      end else begin
        send_item(CMD_UNUSED, AW_IN'($urandom), SW_IN'($urandom), LW_IN'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/svm_pkg.sv
rtl/core/svm_ram.sv
rtl/core/svm_addr_wrap.sv
rtl/core/saturating_voice_mixer_top.sv
dv/svm_mix_checker.sv
dv/saturating_voice_mixer_top_tb.sv
